### hw/rtl/fku_pkg.sv
// fku_pkg: types, codes and constants for the flash key-unlock register block
// used by flash_controller_key_unlock_regs_core; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fku_pkg;

    // default sizes
    localparam int FKU_PAGE_BYTES = 1024;
    localparam int FKU_REG_WORDS  = 49;

    // configuration register reset values
    localparam logic [24:0] FLASH_SIZE_RST = 25'd524288;
    localparam logic [31:0] FLASH_BASE_RST = 32'h0800_0000;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_BASE = 1'd1;

    // unlock key sequence
    localparam logic [31:0] KEY_FIRST  = 32'h4567_0123;
    localparam logic [31:0] KEY_SECOND = 32'hCDEF_89AB;

    // control register bit positions
    localparam int BIT_PG   = 0;
    localparam int BIT_PER  = 1;
    localparam int BIT_STRT = 6;
    localparam int BIT_LOCK = 7;

    // word map of the register window
    localparam int WORD_IDX_W = 8;
    localparam logic [WORD_IDX_W-1:0] W_ACCESS   = 8'd0;
    localparam logic [WORD_IDX_W-1:0] W_CONTROL  = 8'd1;
    localparam logic [WORD_IDX_W-1:0] W_OPTKEY   = 8'd4;
    localparam logic [WORD_IDX_W-1:0] W_KEY      = 8'd5;
    localparam logic [WORD_IDX_W-1:0] W_SPARE    = 8'd6;
    localparam logic [WORD_IDX_W-1:0] W_STATUS   = 8'd8;
    localparam logic [WORD_IDX_W-1:0] W_OPTBYTES = 8'd16;
    localparam logic [WORD_IDX_W-1:0] W_ADDRESS  = 8'd22;
    localparam logic [WORD_IDX_W-1:0] W_WPROT    = 8'd23;

    localparam logic       KIND_READ  = 1'b0;
    localparam logic       KIND_WRITE = 1'b1;
    localparam logic [3:0] WORD_BYTES = 4'd4;

    typedef enum logic [2:0] {
        ST_OK             = 3'd0,
        ST_BAD_WIDTH      = 3'd1,
        ST_BAD_OFFSET     = 3'd2,
        ST_LOCK_PG        = 3'd3,
        ST_ERASE_CONFLICT = 3'd4,
        ST_ERASE_ADDR     = 3'd5,
        ST_PROG_CONFLICT  = 3'd6
    } status_t;

    typedef struct packed {
        logic        kind;
        logic [9:0]  reg_offset;
        logic [3:0]  access_bytes;
        logic [31:0] write_data;
    } in_item_t;

    typedef struct packed {
        logic [31:0] read_data;
        status_t     status_code;
        logic        locked_flag;
        logic        program_enabled;
        logic        erase_strobe;
        logic [23:0] erase_offset;
    } out_item_t;

endpackage

`default_nettype wire

### hw/rtl/flash_controller_key_unlock_regs_core.sv
// flash_controller_key_unlock_regs_core: register block of a flash program/erase controller
// depends on fku_pkg for types, codes and constants
`timescale 1ns / 1ps
`default_nettype none

// Register block of a flash controller with key unlock. Each transfer on the s_ channel is one
// bus access (read or write of a 32-bit register); each produces exactly one transfer on the
// m_ channel with read data, a status code, the lock and programming flags after the access,
// and an erase strobe with the page offset. Throughput is one access per cycle while m_ready is
// high; an access passes the input register, then the result register, with all decode and checks
// done by the logic between them. The input register keeps accepting while a result waits on
// m_ready, so the input side stalls only once both registers are full. Page size must be a power
// of two. cfg_wr_en writes flash size (index 0, kept as a precomputed erase limit) or flash base
// address (index 1); the user must use it only while the block is idle; it is not enforced.
module flash_controller_key_unlock_regs_core #(
    parameter int PAGE_BYTES = fku_pkg::FKU_PAGE_BYTES,
    parameter int REG_WORDS  = fku_pkg::FKU_REG_WORDS
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    // configuration write port
    input  wire                            cfg_wr_en,
    input  wire  [fku_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire  [31:0]                    cfg_wdata,
    // access channel
    input  wire                            s_valid,
    output logic                           s_ready,
    input  wire  fku_pkg::in_item_t        s_data,
    // result channel
    output logic                           m_valid,
    input  wire                            m_ready,
    output fku_pkg::out_item_t             m_data
);
    import fku_pkg::*;

    localparam int PAGE_BITS = $clog2(PAGE_BYTES);
    localparam int LIMIT_W   = 26;
    localparam logic [LIMIT_W-1:0] PAGE_SIZE = LIMIT_W'(PAGE_BYTES);
    localparam logic [8:0]         WORD_LIMIT = 9'(REG_WORDS);

    // input stage
    logic      in_valid_reg;
    in_item_t  in_data_reg;
    // result stage
    logic      out_valid_reg;
    out_item_t out_data_reg;
    out_item_t res;

    // configuration: size minus one page (negative means no page fits), and base
    logic [LIMIT_W-1:0] erase_limit_reg;
    logic [31:0]        flash_base_reg;

    // register file and flags
    logic [31:0] access_ctrl_reg, access_ctrl_next;
    logic [31:0] last_key_reg, last_key_next;
    logic [31:0] option_key_reg, option_key_next;
    logic [31:0] status_word_reg, status_word_next;
    logic [31:0] control_reg, control_next;
    logic [31:0] address_reg, address_next;
    logic [31:0] spare_reg, spare_next;
    logic [31:0] option_bytes_reg, option_bytes_next;
    logic [31:0] wprot_reg, wprot_next;
    logic        locked_reg, locked_next;
    logic        programming_reg, programming_next;

    logic advance;
    logic fire;

    // result register moves when empty or being taken
    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // decode and checks for the access in the input register
    logic [WORD_IDX_W-1:0] idx;
    logic [31:0]           d;
    logic [32:0]           page_diff;
    logic                  erase_addr_ok;

    assign idx = in_data_reg.reg_offset[9:2];
    assign d   = in_data_reg.write_data;

    // address minus base, top bit set when the address lies below the array
    assign page_diff = {1'b0, address_reg} - {1'b0, flash_base_reg};
    assign erase_addr_ok = (address_reg[PAGE_BITS-1:0] == '0) && !page_diff[32]
                         && !erase_limit_reg[LIMIT_W-1]
                         && (page_diff[31:0] <= {7'd0, erase_limit_reg[LIMIT_W-2:0]});

    always_comb begin
        access_ctrl_next  = access_ctrl_reg;
        last_key_next     = last_key_reg;
        option_key_next   = option_key_reg;
        status_word_next  = status_word_reg;
        control_next      = control_reg;
        address_next      = address_reg;
        spare_next        = spare_reg;
        option_bytes_next = option_bytes_reg;
        wprot_next        = wprot_reg;
        locked_next       = locked_reg;
        programming_next  = programming_reg;

        res              = '0;
        res.status_code  = ST_OK;

        if (in_data_reg.access_bytes != WORD_BYTES) begin
            res.status_code = ST_BAD_WIDTH;
        end else if ({1'b0, idx} >= WORD_LIMIT) begin
            res.status_code = ST_BAD_OFFSET;
        end else if (in_data_reg.kind == KIND_READ) begin
            case (idx)
                W_ACCESS:   res.read_data = access_ctrl_reg;
                W_CONTROL:  res.read_data = control_reg;
                W_OPTKEY:   res.read_data = option_key_reg;
                W_KEY:      res.read_data = last_key_reg;
                W_SPARE:    res.read_data = spare_reg;
                W_STATUS:   res.read_data = status_word_reg;
                W_OPTBYTES: res.read_data = option_bytes_reg;
                W_ADDRESS:  res.read_data = address_reg;
                W_WPROT:    res.read_data = wprot_reg;
                default:    res.read_data = '0;
            endcase
        end else begin
            case (idx)
                W_ACCESS:   access_ctrl_next = d;
                W_OPTKEY:   option_key_next = d;
                W_SPARE:    spare_next = d;
                W_STATUS:   status_word_next = d;
                W_OPTBYTES: option_bytes_next = d;
                W_ADDRESS:  address_next = d;
                W_WPROT:    wprot_next = d;
                W_KEY: begin
                    // second key right after the first unlocks
                    if (last_key_reg == KEY_FIRST && d == KEY_SECOND) begin
                        control_next[BIT_LOCK] = 1'b0;
                        locked_next = 1'b0;
                    end
                    last_key_next = d;
                end
                W_CONTROL: begin
                    if (!locked_reg && d[BIT_LOCK]) begin
                        // lock request
                        if (d[BIT_PG]) begin
                            res.status_code = ST_LOCK_PG;
                        end else begin
                            locked_next  = 1'b1;
                            control_next = d;
                        end
                    end else if (control_reg[BIT_PER] && d[BIT_STRT]) begin
                        // page erase start
                        if (d[BIT_PG] || d[BIT_LOCK]) begin
                            res.status_code = ST_ERASE_CONFLICT;
                        end else if (!erase_addr_ok) begin
                            res.status_code = ST_ERASE_ADDR;
                        end else begin
                            res.erase_strobe = 1'b1;
                            res.erase_offset = page_diff[23:0];
                            control_next     = d;
                        end
                    end else if (d[BIT_PG]) begin
                        // program enable request
                        if (d[BIT_LOCK] || d[BIT_PER]) begin
                            res.status_code = ST_PROG_CONFLICT;
                        end else begin
                            programming_next = 1'b1;
                            control_next     = d;
                        end
                    end else begin
                        if (d != '0) begin
                            programming_next = 1'b0;
                        end
                        control_next = d;
                    end
                end
                default: ;
            endcase
        end

        res.locked_flag     = locked_next;
        res.program_enabled = programming_next;
    end

    // handshake control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        if (fire) begin
            out_data_reg <= res;
        end
    end

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            erase_limit_reg <= {1'b0, FLASH_SIZE_RST} - PAGE_SIZE;
            flash_base_reg  <= FLASH_BASE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_FLASH_SIZE: erase_limit_reg <= {1'b0, cfg_wdata[24:0]} - PAGE_SIZE;
                CFG_FLASH_BASE: flash_base_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // register file, updated once per transfer through the result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            access_ctrl_reg  <= '0;
            last_key_reg     <= '0;
            option_key_reg   <= '0;
            status_word_reg  <= '0;
            control_reg      <= '0;
            address_reg      <= '0;
            spare_reg        <= '0;
            option_bytes_reg <= '0;
            wprot_reg        <= '0;
            locked_reg       <= 1'b1;
            programming_reg  <= 1'b0;
        end else if (fire) begin
            access_ctrl_reg  <= access_ctrl_next;
            last_key_reg     <= last_key_next;
            option_key_reg   <= option_key_next;
            status_word_reg  <= status_word_next;
            control_reg      <= control_next;
            address_reg      <= address_next;
            spare_reg        <= spare_next;
            option_bytes_reg <= option_bytes_next;
            wprot_reg        <= wprot_next;
            locked_reg       <= locked_next;
            programming_reg  <= programming_next;
        end
    end

    // the controller comes out of reset locked
    assert property (@(posedge aclk) !aresetn |=> locked_reg)
        else $error("controller not locked after reset");

    // an erase strobe only goes out with a good status
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.erase_strobe) |-> (m_data.status_code == ST_OK))
        else $error("erase strobe with error status");

    // a rejected access leaves control state untouched
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && res.status_code != ST_OK)
        |=> ($stable(control_reg) && $stable(locked_reg) && $stable(programming_reg)))
        else $error("rejected access changed control state");

    // the flags shown with a result match the stored flags right after it
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> (m_data.locked_flag == locked_reg && m_data.program_enabled == programming_reg))
        else $error("result flags disagree with stored flags");

endmodule

`default_nettype wire

### tb/flash_controller_key_unlock_regs_core_tb.sv
// flash_controller_key_unlock_regs_core_tb: self-checking bench for the flash key-unlock
// register block; holds its own model of the register file, keys, lock and erase checks
// depends on fku_pkg and the core
`timescale 1ns / 1ps

module flash_controller_key_unlock_regs_core_tb;

    import fku_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 4;   // pipeline is two deep, a few spare cycles before a setting
    localparam int DRAIN_CYCLES  = 10;
    localparam int PRINT_LIMIT   = 200;

    // how a side spaces its transfers
    localparam int PACE_NONE   = 0;
    localparam int PACE_RANDOM = 1;
    localparam int PACE_BURSTY = 2;

    // kinds of random access sequences
    localparam int SEQ_UNLOCK  = 0;
    localparam int SEQ_ERASE   = 1;
    localparam int SEQ_CONTROL = 2;
    localparam int SEQ_REG_RW  = 3;
    localparam int SEQ_NOISE   = 4;

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]        cfg_wdata;
    logic               s_valid;
    logic               s_ready;
    in_item_t           s_data;
    logic               m_valid;
    logic               m_ready;
    out_item_t          m_data;

    flash_controller_key_unlock_regs_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // shadow copy of the block: settings, register words, lock and programming flags
    logic [24:0] fl_size    = FLASH_SIZE_RST;
    logic [31:0] fl_base    = FLASH_BASE_RST;
    logic [31:0] acr_q      = '0;
    logic [31:0] ctrl_q     = '0;
    logic [31:0] optkey_q   = '0;
    logic [31:0] key_q      = '0;
    logic [31:0] spare_q    = '0;
    logic [31:0] status_q   = '0;
    logic [31:0] optbytes_q = '0;
    logic [31:0] addr_q     = '0;
    logic [31:0] wprot_q    = '0;
    logic        locked_q   = 1'b1;
    logic        prog_q     = 1'b0;

    // responses predicted for accepted accesses, oldest first
    out_item_t access_results[$];

    int mismatches    = 0;
    int accesses_sent = 0;
    int cycle_count   = 0;
    int tx_pace       = PACE_RANDOM;
    int rx_pace       = PACE_RANDOM;
    bit tx_holding    = 1'b0;   // s_valid left high for a back-to-back transfer

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit, sized for every transfer waiting out the longest gap on both sides
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("flash_controller_key_unlock_regs_core: mismatch");
            $finish;
        end
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("%0t: %s is 0x%0h, predicted 0x%0h", $time, field, got, want);
    endtask

    function automatic int draw_wait(input int mode);
        if (mode == PACE_NONE)
            return 0;
        if (mode == PACE_BURSTY)
            return ($urandom_range(0, 7) == 0) ? 8 : 0;
        return $urandom_range(0, 8);
    endfunction

    // one bus access: decode, register update, control checks and erase outputs
    function automatic out_item_t flash_regs_access(input in_item_t acc);
        out_item_t   res;
        logic [7:0]  widx;
        logic [31:0] d;
        logic [32:0] page_off;
        res = '0;
        res.status_code = ST_OK;
        widx = acc.reg_offset[9:2];
        d = acc.write_data;
        if (acc.access_bytes != WORD_BYTES) begin
            res.status_code = ST_BAD_WIDTH;
        end else if (widx >= FKU_REG_WORDS) begin
            res.status_code = ST_BAD_OFFSET;
        end else if (acc.kind == KIND_READ) begin
            case (widx)
                W_ACCESS:   res.read_data = acr_q;
                W_CONTROL:  res.read_data = ctrl_q;
                W_OPTKEY:   res.read_data = optkey_q;
                W_KEY:      res.read_data = key_q;
                W_SPARE:    res.read_data = spare_q;
                W_STATUS:   res.read_data = status_q;
                W_OPTBYTES: res.read_data = optbytes_q;
                W_ADDRESS:  res.read_data = addr_q;
                W_WPROT:    res.read_data = wprot_q;
                default:    res.read_data = '0;
            endcase
        end else begin
            case (widx)
                W_ACCESS:   acr_q = d;
                W_OPTKEY:   optkey_q = d;
                W_SPARE:    spare_q = d;
                W_STATUS:   status_q = d;
                W_OPTBYTES: optbytes_q = d;
                W_ADDRESS:  addr_q = d;
                W_WPROT:    wprot_q = d;
                W_KEY: begin
                    // second key right after the first one opens the controller
                    if (key_q == KEY_FIRST && d == KEY_SECOND) begin
                        ctrl_q[BIT_LOCK] = 1'b0;
                        locked_q = 1'b0;
                    end
                    key_q = d;
                end
                W_CONTROL: begin
                    page_off = {1'b0, addr_q} - {1'b0, fl_base};
                    if (!locked_q && d[BIT_LOCK]) begin
                        if (d[BIT_PG])
                            res.status_code = ST_LOCK_PG;
                        else
                            locked_q = 1'b1;
                    end else if (ctrl_q[BIT_PER] && d[BIT_STRT]) begin
                        if (d[BIT_PG] || d[BIT_LOCK]) begin
                            res.status_code = ST_ERASE_CONFLICT;
                        end else if ((addr_q % FKU_PAGE_BYTES) != 0 || addr_q < fl_base ||
                                     page_off + FKU_PAGE_BYTES > fl_size) begin
                            res.status_code = ST_ERASE_ADDR;
                        end else begin
                            res.erase_strobe = 1'b1;
                            res.erase_offset = page_off[23:0];
                        end
                    end else if (d[BIT_PG]) begin
                        if (d[BIT_LOCK] || d[BIT_PER])
                            res.status_code = ST_PROG_CONFLICT;
                        else
                            prog_q = 1'b1;
                    end else if (d != '0) begin
                        prog_q = 1'b0;
                    end
                    // rejected control writes leave the register alone
                    if (res.status_code == ST_OK)
                        ctrl_q = d;
                end
                default: ;
            endcase
        end
        res.locked_flag = locked_q;
        res.program_enabled = prog_q;
        return res;
    endfunction

    function automatic in_item_t word_access(input logic kind, input logic [7:0] widx,
                                             input logic [31:0] data);
        in_item_t   acc;
        logic [1:0] byte_sel;
        byte_sel = 2'($urandom_range(0, 3));
        acc.kind = kind;
        acc.reg_offset = {widx, byte_sel};
        acc.access_bytes = WORD_BYTES;
        acc.write_data = data;
        return acc;
    endfunction

    function automatic logic [7:0] pick_word();
        case ($urandom_range(0, 10))
            0:       return W_ACCESS;
            1:       return W_CONTROL;
            2:       return W_OPTKEY;
            3:       return W_KEY;
            4:       return W_SPARE;
            5:       return W_STATUS;
            6:       return W_OPTBYTES;
            7:       return W_ADDRESS;
            8:       return W_WPROT;
            9:       return 8'($urandom_range(0, 63));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // mostly page addresses around the array, some unaligned or below the base
    function automatic logic [31:0] erase_address();
        int unsigned pages;
        pages = fl_size / FKU_PAGE_BYTES;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return fl_base + FKU_PAGE_BYTES * $urandom_range(0, pages);
            6:                return fl_base + fl_size - FKU_PAGE_BYTES;
            7:                return fl_base + $urandom_range(1, FKU_PAGE_BYTES - 1);
            8:                return fl_base - FKU_PAGE_BYTES * $urandom_range(1, 4);
            default:          return $urandom;
        endcase
    endfunction

    // one access transfer; the prediction is made once the block takes it
    task automatic send_access(input in_item_t acc);
        int gap;
        s_valid <= 1'b1;
        s_data <= acc;
        do @(posedge aclk); while (s_ready !== 1'b1);
        access_results.push_back(flash_regs_access(acc));
        accesses_sent++;
        gap = draw_wait(tx_pace);
        if (gap > 0) begin
            s_valid <= 1'b0;
            tx_holding = 1'b0;
            repeat (gap) @(posedge aclk);
        end else begin
            tx_holding = 1'b1;
        end
    endtask

    // stop sending and let every predicted response come back
    task automatic wait_idle();
        if (tx_holding) begin
            s_valid <= 1'b0;
            tx_holding = 1'b0;
        end
        while (access_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic apply_settings(input logic [24:0] array_bytes, input logic [31:0] base);
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_FLASH_SIZE;
        cfg_wdata <= {7'd0, array_bytes};
        @(posedge aclk);
        cfg_index <= CFG_FLASH_BASE;
        cfg_wdata <= base;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        fl_size = array_bytes;
        fl_base = base;
    endtask

    // random traffic built from unlock, erase, control and register read/write sequences plus some noise
    task automatic run_random(input int count);
        int          stop_at;
        int          pick;
        int          seq;
        logic [31:0] d;
        logic [31:0] k1;
        logic [31:0] k2;
        logic [4:0]  flip_pos;
        logic [7:0]  widx;
        in_item_t    acc;
        stop_at = accesses_sent + count;
        while (accesses_sent < stop_at) begin
            if ($urandom_range(0, 5) == 0) begin
                tx_pace = $urandom_range(PACE_NONE, PACE_BURSTY);
                rx_pace = $urandom_range(PACE_NONE, PACE_BURSTY);
            end
            pick = $urandom_range(0, 9);
            if (pick < 2)      seq = SEQ_UNLOCK;
            else if (pick < 5) seq = SEQ_ERASE;
            else if (pick < 7) seq = SEQ_CONTROL;
            else if (pick < 9) seq = SEQ_REG_RW;
            else               seq = SEQ_NOISE;
            case (seq)
                SEQ_UNLOCK: begin
                    k1 = ($urandom_range(0, 7) == 0) ? $urandom : KEY_FIRST;
                    k2 = KEY_SECOND;
                    if ($urandom_range(0, 7) == 0) begin
                        flip_pos = 5'($urandom_range(0, 31));
                        k2[flip_pos] = ~k2[flip_pos];
                    end
                    send_access(word_access(KIND_WRITE, W_KEY, k1));
                    send_access(word_access(KIND_WRITE, W_KEY, k2));
                end
                SEQ_ERASE: begin
                    d = '0;
                    d[BIT_PER] = 1'b1;
                    send_access(word_access(KIND_WRITE, W_CONTROL, d));
                    send_access(word_access(KIND_WRITE, W_ADDRESS, erase_address()));
                    d[BIT_STRT] = 1'b1;
                    case ($urandom_range(0, 9))
                        0: d[BIT_PG] = 1'b1;
                        1: d[BIT_LOCK] = 1'b1;
                        default: ;
                    endcase
                    send_access(word_access(KIND_WRITE, W_CONTROL, d));
                end
                SEQ_CONTROL: begin
                    d = ($urandom_range(0, 5) == 0) ? $urandom : '0;
                    d[BIT_PG] = ($urandom_range(0, 3) != 0);
                    d[BIT_PER] = ($urandom_range(0, 4) == 0);
                    d[BIT_LOCK] = ($urandom_range(0, 4) == 0);
                    d[BIT_STRT] = ($urandom_range(0, 5) == 0);
                    if ($urandom_range(0, 7) == 0)
                        d = '0;
                    send_access(word_access(KIND_WRITE, W_CONTROL, d));
                    if ($urandom_range(0, 2) == 0)
                        send_access(word_access(KIND_READ, W_CONTROL, $urandom));
                end
                SEQ_REG_RW: begin
                    widx = pick_word();
                    case ($urandom_range(0, 3))
                        0:       d = '0;
                        1:       d = '1;
                        default: d = $urandom;
                    endcase
                    acc = word_access(KIND_WRITE, widx, d);
                    if ($urandom_range(0, 9) == 0)
                        acc.access_bytes = 4'($urandom_range(0, 15));
                    send_access(acc);
                    acc = word_access(KIND_READ, widx, $urandom);
                    if ($urandom_range(0, 9) == 0)
                        acc.access_bytes = 4'($urandom_range(0, 15));
                    send_access(acc);
                end
                default: begin
                    acc.kind = 1'($urandom_range(0, 1));
                    acc.reg_offset = 10'($urandom_range(0, 1023));
                    acc.access_bytes = $urandom_range(0, 1) ? WORD_BYTES
                                                            : 4'($urandom_range(0, 15));
                    acc.write_data = $urandom;
                    send_access(acc);
                end
            endcase
        end
    endtask

    // reset values, width and offset errors, unmapped words, low offset bits
    task automatic test_reset_and_decode();
        in_item_t   acc;
        logic [7:0] past_end;
        past_end = 8'(FKU_REG_WORDS);
        send_access(word_access(KIND_READ, W_ACCESS, '0));
        acc = word_access(KIND_READ, W_SPARE, '0);
        acc.access_bytes = 4'h0;
        send_access(acc);
        acc = word_access(KIND_WRITE, W_SPARE, '1);
        acc.access_bytes = 4'hF;
        send_access(acc);
        acc.kind = KIND_READ;
        acc.reg_offset = 10'h3FF;
        acc.access_bytes = WORD_BYTES;
        send_access(acc);
        send_access(word_access(KIND_READ, past_end, '0));
        send_access(word_access(KIND_WRITE, past_end - 8'd1, '1));
        send_access(word_access(KIND_READ, past_end - 8'd1, '0));
        send_access(word_access(KIND_WRITE, W_SPARE, '1));
        send_access(word_access(KIND_READ, W_SPARE, '0));
    endtask

    // program request while locked, lone second key, then the full key pair
    task automatic test_key_unlock();
        logic [31:0] d;
        d = '0;
        d[BIT_PG] = 1'b1;
        d[BIT_LOCK] = 1'b1;
        send_access(word_access(KIND_WRITE, W_CONTROL, d));
        send_access(word_access(KIND_WRITE, W_KEY, KEY_SECOND));
        send_access(word_access(KIND_WRITE, W_KEY, KEY_FIRST));
        send_access(word_access(KIND_WRITE, W_KEY, KEY_SECOND));
    endtask

    // lock with PG, program enable, zero write keeps it, other write clears it
    task automatic test_control_checks();
        logic [31:0] d;
        d = '0;
        d[BIT_PG] = 1'b1;
        d[BIT_LOCK] = 1'b1;
        send_access(word_access(KIND_WRITE, W_CONTROL, d));
        d[BIT_LOCK] = 1'b0;
        send_access(word_access(KIND_WRITE, W_CONTROL, d));
        send_access(word_access(KIND_WRITE, W_CONTROL, '0));
        d = '0;
        d[BIT_PER] = 1'b1;
        send_access(word_access(KIND_WRITE, W_CONTROL, d));
    endtask

    // good erase, conflicts, unaligned, below base, last page, one page past the end
    task automatic test_page_erase();
        logic [31:0] strt;
        logic [31:0] d;
        strt = '0;
        strt[BIT_PER] = 1'b1;
        strt[BIT_STRT] = 1'b1;
        send_access(word_access(KIND_WRITE, W_ADDRESS, fl_base + 3 * FKU_PAGE_BYTES));
        send_access(word_access(KIND_WRITE, W_CONTROL, strt));
        d = strt;
        d[BIT_PG] = 1'b1;
        send_access(word_access(KIND_WRITE, W_CONTROL, d));
        send_access(word_access(KIND_WRITE, W_ADDRESS, fl_base + 1));
        send_access(word_access(KIND_WRITE, W_CONTROL, strt));
        send_access(word_access(KIND_WRITE, W_ADDRESS, fl_base - FKU_PAGE_BYTES));
        send_access(word_access(KIND_WRITE, W_CONTROL, strt));
        send_access(word_access(KIND_WRITE, W_ADDRESS, fl_base + fl_size - FKU_PAGE_BYTES));
        send_access(word_access(KIND_WRITE, W_CONTROL, strt));
        send_access(word_access(KIND_WRITE, W_ADDRESS, fl_base + fl_size));
        send_access(word_access(KIND_WRITE, W_CONTROL, strt));
        // relock, then an erase with LOCK set goes down the erase path as a conflict
        d = '0;
        d[BIT_PER] = 1'b1;
        d[BIT_LOCK] = 1'b1;
        send_access(word_access(KIND_WRITE, W_CONTROL, d));
        d[BIT_STRT] = 1'b1;
        send_access(word_access(KIND_WRITE, W_CONTROL, d));
    endtask

    // smallest, largest, wrapping and sub-page arrays, then back to reset values
    task automatic test_config_extremes();
        apply_settings(25'd1024, 32'h0000_0000);
        run_random(30);
        apply_settings(25'h100_0000, 32'hFFFF_FC00);
        run_random(30);
        apply_settings(25'd512, 32'h0000_1000);
        run_random(30);
        apply_settings(25'h100_0000, 32'hFFFF_FFFF);
        run_random(30);
        apply_settings(25'h100_0000, 32'h0000_0000);
        run_random(30);
        apply_settings(FLASH_SIZE_RST, FLASH_BASE_RST);
    endtask

    task automatic test_random_traffic();
        run_random(300);
    endtask

    // response side: stall before each transfer, compare field by field
    initial begin : result_monitor
        out_item_t want;
        int        stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = draw_wait(rx_pace);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            if (access_results.size() == 0) begin
                report_mismatch("response with no pending access", m_data.read_data, '0);
            end else begin
                want = access_results.pop_front();
                if (m_data.read_data !== want.read_data)
                    report_mismatch("read_data", m_data.read_data, want.read_data);
                if (m_data.status_code !== want.status_code)
                    report_mismatch("status_code", 32'(m_data.status_code),
                                    32'(want.status_code));
                if (m_data.locked_flag !== want.locked_flag)
                    report_mismatch("locked_flag", 32'(m_data.locked_flag),
                                    32'(want.locked_flag));
                if (m_data.program_enabled !== want.program_enabled)
                    report_mismatch("program_enabled", 32'(m_data.program_enabled),
                                    32'(want.program_enabled));
                if (m_data.erase_strobe !== want.erase_strobe)
                    report_mismatch("erase_strobe", 32'(m_data.erase_strobe),
                                    32'(want.erase_strobe));
                if (m_data.erase_offset !== want.erase_offset)
                    report_mismatch("erase_offset", 32'(m_data.erase_offset),
                                    32'(want.erase_offset));
            end
        end
    end

    initial begin
        aresetn <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_FLASH_SIZE;
        cfg_wdata <= '0;
        s_valid <= 1'b0;
        s_data <= '0;
        m_ready <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_and_decode();
        wait_idle();
        test_key_unlock();
        test_control_checks();
        wait_idle();
        test_page_erase();
        test_config_extremes();
        test_random_traffic();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("flash_controller_key_unlock_regs_core: match");
        end else begin
            $display("flash_controller_key_unlock_regs_core: mismatch");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/fku_pkg.sv
hw/rtl/flash_controller_key_unlock_regs_core.sv
tb/flash_controller_key_unlock_regs_core_tb.sv
